// ----- hdl/bline_pkg.sv -----
`default_nettype none

package bline_pkg;

    // Segment queue between front end and stepper
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } step_state_t;

endpackage

`default_nettype wire

// ----- hdl/bline_queue.sv -----
`default_nettype none

module bline_queue
#(
    parameter int WIDTH = 27
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  not_empty
);
    import bline_pkg::*;

    logic [WIDTH-1:0]     mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full      = (count_reg == QCNT_BITS'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bline_front.sv -----
`default_nettype none

module bline_front
#(
    parameter int COORD_BITS = 6
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [COORD_BITS-1:0]   start_x,
    input  wire logic [COORD_BITS-1:0]   start_y,
    input  wire logic [COORD_BITS-1:0]   end_x,
    input  wire logic [COORD_BITS-1:0]   end_y,
    output logic                         q_wr_en,
    output logic [4*COORD_BITS+2:0]      q_wr_data,
    input  wire logic                    q_full
);
    localparam int C = COORD_BITS;

    logic         hold_valid_reg;
    logic [C-1:0] ax_reg;
    logic [C-1:0] ay_reg;
    logic [C-1:0] bx_reg;
    logic [C-1:0] by_reg;

    logic         mirror_x;
    logic         mirror_y;
    logic         axes_swapped;
    logic [C-1:0] adx;
    logic [C-1:0] ady;
    logic [C-1:0] dmaj;
    logic [C-1:0] dmin;
    logic         zero_len;
    logic         done;

    // Fold into the first octant; ties go to the mirrored / swapped side
    always_comb
    begin
        mirror_x     = !(bx_reg > ax_reg);
        mirror_y     = !(by_reg > ay_reg);
        adx          = mirror_x ? (ax_reg - bx_reg) : (bx_reg - ax_reg);
        ady          = mirror_y ? (ay_reg - by_reg) : (by_reg - ay_reg);
        axes_swapped = !(adx > ady);
        dmaj         = axes_swapped ? ady : adx;
        dmin         = axes_swapped ? adx : ady;
        zero_len     = (dmaj == '0);
    end

    // Zero-length segments are dropped here and never reach the stepper
    assign done      = hold_valid_reg && (zero_len || !q_full);
    assign q_wr_en   = hold_valid_reg && !zero_len && !q_full;
    assign in_ready  = !hold_valid_reg || done;
    assign q_wr_data = {dmin, dmaj, axes_swapped, mirror_y, mirror_x, ay_reg, ax_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg <= start_x;
            ay_reg <= start_y;
            bx_reg <= end_x;
            by_reg <= end_y;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bline_stepper.sv -----
`default_nettype none

module bline_stepper
#(
    parameter int COORD_BITS = 6
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_not_empty,
    input  wire logic [4*COORD_BITS+2:0] q_rd_data,
    output logic                         q_rd_en,
    output logic                         busy,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic                         last_pixel
);
    import bline_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int EW = C + 3;   // error term
    localparam int AW = C + 2;   // advance step

    step_state_t state_reg, state_next;

    logic [C-1:0]          px_reg, px_next;
    logic [C-1:0]          py_reg, py_next;
    logic [C-1:0]          remain_reg, remain_next;
    logic signed [EW-1:0]  err_reg, err_next;
    logic [C:0]            keep_reg, keep_next;
    logic signed [AW-1:0]  adv_reg, adv_next;
    logic                  swap_reg, swap_next;
    logic                  mx_reg, mx_next;
    logic                  my_reg, my_next;
    logic                  ov_reg, ov_next;
    logic [C-1:0]          ox_reg, ox_next;
    logic [C-1:0]          oy_reg, oy_next;
    logic                  ol_reg, ol_next;

    logic [C-1:0] q_ax, q_ay, q_dmaj, q_dmin;
    logic         q_mx, q_my, q_swap;
    logic         out_free;
    logic         step;
    logic         minor_step;
    logic [C-1:0] inc_x, inc_y;

    assign {q_dmin, q_dmaj, q_swap, q_my, q_mx, q_ay, q_ax} = q_rd_data;

    assign out_free   = !ov_reg || out_ready;
    assign step       = (state_reg == ST_RUN) && out_free;
    assign minor_step = !err_reg[EW-1];
    assign inc_x      = mx_reg ? '1 : C'(1);
    assign inc_y      = my_reg ? '1 : C'(1);

    assign busy       = (state_reg == ST_RUN);
    assign out_valid  = ov_reg;
    assign pixel_x    = ox_reg;
    assign pixel_y    = oy_reg;
    assign last_pixel = ol_reg;

    always_comb
    begin
        state_next  = state_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        remain_next = remain_reg;
        err_next    = err_reg;
        keep_next   = keep_reg;
        adv_next    = adv_reg;
        swap_next   = swap_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        ov_next     = ov_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ol_next     = ol_reg;
        q_rd_en     = 1'b0;

        if (out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_rd_en     = 1'b1;
                    px_next     = q_ax;
                    py_next     = q_ay;
                    remain_next = q_dmaj;
                    keep_next   = {q_dmin, 1'b0};
                    adv_next    = $signed({1'b0, q_dmin, 1'b0}) - $signed({1'b0, q_dmaj, 1'b0});
                    err_next    = $signed({2'b00, q_dmin, 1'b0}) - $signed({3'b000, q_dmaj});
                    swap_next   = q_swap;
                    mx_next     = q_mx;
                    my_next     = q_my;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    ov_next = 1'b1;
                    ox_next = px_reg;
                    oy_next = py_reg;
                    ol_next = (remain_reg == C'(1));

                    if (!swap_reg || minor_step)
                    begin
                        px_next = px_reg + inc_x;
                    end
                    if (swap_reg || minor_step)
                    begin
                        py_next = py_reg + inc_y;
                    end

                    if (minor_step)
                    begin
                        err_next = err_reg + $signed({adv_reg[AW-1], adv_reg});
                    end
                    else
                    begin
                        err_next = err_reg + $signed({2'b00, keep_reg});
                    end

                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == C'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        remain_reg <= remain_next;
        err_reg    <= err_next;
        keep_reg   <= keep_next;
        adv_reg    <= adv_next;
        swap_reg   <= swap_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ol_reg     <= ol_next;
    end

endmodule

`default_nettype wire

// ----- hdl/bresenham_line_generator.sv -----
// Throughput: one pixel per cycle while m_axis_tready lets the output drain; a segment holds
// the stepper for a load step and then one step per pixel, and yields max(|dx|,|dy|) pixels.
// Zero-length segments are dropped in the front end.
// Reset: rst_n asynchronous, active low; clears the queue, stepper and output valid.
`default_nettype none

module bresenham_line_generator
#(
    parameter int COORD_BITS = 6
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    // start_x, start_y, end_x, end_y (lowest bits first), zero padded to bytes
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,

    // pixel_x, pixel_y (lowest bits first), zero padded to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                   m_axis_tlast,   // last_pixel
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready
);
    localparam int C      = COORD_BITS;
    localparam int QW     = 4*C + 3;
    localparam int OUT_DW = ((2*C+7)/8)*8;

    // Front end -> queue
    logic          q_wr_en;
    logic [QW-1:0] q_wr_data;
    logic          q_full;

    // Queue -> stepper
    logic          q_rd_en;
    logic [QW-1:0] q_rd_data;
    logic          q_not_empty;

    logic          step_busy;
    logic [C-1:0]  pixel_x;
    logic [C-1:0]  pixel_y;

    // Front end: holds one request, folds it into the first octant and
    // queues the folded segment (start point, mirrors, swap, extents).
    bline_front
    #(
        .COORD_BITS (C)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .start_x   (s_axis_tdata[C-1:0]),
        .start_y   (s_axis_tdata[2*C-1:C]),
        .end_x     (s_axis_tdata[3*C-1:2*C]),
        .end_y     (s_axis_tdata[4*C-1:3*C]),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    // Two-entry queue so the front end takes the next segment while
    // the stepper is still drawing.
    bline_queue
    #(
        .WIDTH (QW)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr_en),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_rd_en),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    // Stepper: Bresenham error recurrence along the major axis, one
    // pixel per cycle while the output is free, into a registered output stage.
    bline_stepper
    #(
        .COORD_BITS (C)
    )
    u_stepper
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rd_data   (q_rd_data),
        .q_rd_en     (q_rd_en),
        .busy        (step_busy),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DW'({pixel_y, pixel_x});

    // Queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr_en |-> !q_full)
        else $error("segment queue written while full");

    // Queue never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |-> q_not_empty)
        else $error("segment queue read while empty");

    // A new segment is only taken once the stepper has finished the last one
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |-> !step_busy)
        else $error("segment taken while stepper busy");

    // Stepper becomes busy straight after taking a segment
    a_busy_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |=> step_busy)
        else $error("stepper did not start after taking a segment");

endmodule

`default_nettype wire
